>>> hdl/assert_macros.svh
// Assertion macros used by the deque datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion violated");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion violated");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion violated");

`endif

>>> hdl/dq_pkg.sv
// Types and codes shared by the deque controller, datapath and top level.
package dq_pkg;

  localparam int OP_W  = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 10;
  localparam int CNT_W = 11;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ       = 3'd4;
  localparam logic [OP_W-1:0] OP_WRITE      = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] data;
    logic [CNT_W-1:0] count;
    logic [ST_W-1:0]  status;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } dq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_hold;
  } dq_sts_t;

endpackage

>>> hdl/double_ended_queue.sv
// Top level of the bounded double-ended queue: controller plus datapath.
// Usage:
//   Request channel (req_valid / req_stall / req) carries one operation per
//   item: push front, push back, pop front, pop back, read or write at a
//   logical index from the front end.
//   Response channel (rsp_valid / rsp_stall / rsp) returns exactly one item
//   per request: the element popped or read, the count after the operation
//   and a status (ok, pop while empty, push while full, index out of range).
// Sequence:
//   Each item passes through capture, execute on the single port of the
//   element store, then load of the registered read data into the result
//   register; the next item is accepted only after the load. req_stall is
//   high from capture until the result is loaded.
// Stall:
//   The result register holds while rsp_stall is high; the next item can be
//   accepted and executed meanwhile, and waits to load until the register
//   frees up.
// Reset:
//   rst clears the controller state, the front pointer, the element count and
//   the result valid flag. The element store is not cleared; only written slots are read.
module double_ended_queue #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_stall,
  input  dq_pkg::req_t req,
  output logic         rsp_valid,
  input  logic         rsp_stall,
  output dq_pkg::rsp_t rsp
);

  dq_pkg::dq_cmd_t cmd;
  dq_pkg::dq_sts_t sts;

  // sequence each item through capture, execute and load
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold the ring buffer, pointers and result register
  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

>>> hdl/dq_ctrl.sv
// Sequencing state machine for the deque: accept, execute, load result.
module dq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  dq_pkg::dq_sts_t sts,
  output dq_pkg::dq_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.load    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        // wait here while the previous result is still stalled
        if (!sts.out_hold) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/dq_datapath.sv
// Ring-buffer storage, pointers, slot arithmetic and result register of the deque.
`include "assert_macros.svh"

module dq_datapath #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  dq_pkg::req_t    req,
  input  dq_pkg::dq_cmd_t cmd,
  output dq_pkg::dq_sts_t sts,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output dq_pkg::rsp_t    rsp
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CW > dq_pkg::POS_W) ? CW : dq_pkg::POS_W;
  localparam int KW = (CW > dq_pkg::CNT_W) ? CW : dq_pkg::CNT_W;
  localparam int EW = (DATA_WIDTH > dq_pkg::VAL_W) ? DATA_WIDTH : dq_pkg::VAL_W;

  // captured item
  logic [dq_pkg::OP_W-1:0]  op;
  logic [dq_pkg::VAL_W-1:0] value;
  logic [dq_pkg::POS_W-1:0] position;

  // queue state
  logic [PW-1:0] front;
  logic [PW-1:0] front_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // execute results
  logic [dq_pkg::ST_W-1:0] status;
  logic [dq_pkg::ST_W-1:0] status_next;
  logic                    rd_flag;
  logic [DATA_WIDTH-1:0]   rdata;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [PW-1:0]   offset;
  logic [PW:0]     sum;
  logic [PW-1:0]   slot;
  logic [PW-1:0]   front_inc;
  logic [CW-1:0]   count_dec;
  logic [WW-1:0]   pos_wide;
  logic [WW-1:0]   count_wide;
  logic            full;
  logic            empty;
  logic            in_range;
  logic            mem_wr;
  logic            mem_rd;
  logic [EW-1:0]   value_ext;
  logic [EW-1:0]   rdata_ext;
  logic [KW-1:0]   count_ext;

  assign full       = (count == CW'(DEPTH));
  assign empty      = (count == '0);
  assign count_dec  = count - 1'b1;
  assign pos_wide   = WW'(position);
  assign count_wide = WW'(count);
  assign in_range   = (pos_wide < count_wide);
  assign front_inc  = (front == PW'(DEPTH - 1)) ? '0 : front + 1'b1;

  // physical slot = (front + offset) mod DEPTH, offset below DEPTH
  assign sum  = {1'b0, front} + {1'b0, offset};
  assign slot = (sum >= (PW+1)'(DEPTH)) ? PW'(sum - (PW+1)'(DEPTH)) : sum[PW-1:0];

  always_comb begin
    offset      = '0;
    mem_wr      = 1'b0;
    mem_rd      = 1'b0;
    front_next  = front;
    count_next  = count;
    status_next = dq_pkg::ST_OK;
    case (op)
      dq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status_next = dq_pkg::ST_FULL;
        end else begin
          offset     = PW'(DEPTH - 1);
          mem_wr     = 1'b1;
          front_next = slot;
          count_next = count + 1'b1;
        end
      end
      dq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_next = dq_pkg::ST_FULL;
        end else begin
          offset     = count[PW-1:0];
          mem_wr     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status_next = dq_pkg::ST_EMPTY;
        end else begin
          mem_rd     = 1'b1;
          front_next = front_inc;
          count_next = count_dec;
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_next = dq_pkg::ST_EMPTY;
        end else begin
          offset     = count_dec[PW-1:0];
          mem_rd     = 1'b1;
          count_next = count_dec;
        end
      end
      dq_pkg::OP_READ: begin
        if (!in_range) begin
          status_next = dq_pkg::ST_RANGE;
        end else begin
          offset = pos_wide[PW-1:0];
          mem_rd = 1'b1;
        end
      end
      dq_pkg::OP_WRITE: begin
        if (!in_range) begin
          status_next = dq_pkg::ST_RANGE;
        end else begin
          offset = pos_wide[PW-1:0];
          mem_wr = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign value_ext = EW'(value);

  // capture the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op       <= req.op;
      value    <= req.value;
      position <= req.position;
    end
  end

  // element store: one port, registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_wr) begin
      mem[slot] <= value_ext[DATA_WIDTH-1:0];
    end
    if (cmd.exec && mem_rd) begin
      rdata <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status  <= status_next;
      rd_flag <= mem_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      front <= front_next;
      count <= count_next;
    end
  end

  assign rdata_ext = EW'(rdata);
  assign count_ext = KW'(count);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp.data   <= rd_flag ? rdata_ext[dq_pkg::VAL_W-1:0] : '0;
      rsp.count  <= count_ext[dq_pkg::CNT_W-1:0];
      rsp.status <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  assign sts.out_hold = rsp_valid && rsp_stall;

  `ASSERT_ALWAYS(a_count_max, clk, rst, count <= CW'(DEPTH))
  `ASSERT_IMPLIES(a_load_free, clk, rst, cmd.load, !(rsp_valid && rsp_stall))
  `ASSERT_NEXT(a_push_grows, clk, rst, cmd.exec && mem_wr && (op == dq_pkg::OP_PUSH_FRONT || op == dq_pkg::OP_PUSH_BACK), count == $past(count) + 1'b1)
  `ASSERT_IMPLIES(a_err_zero, clk, rst, rsp_valid && rsp.status != dq_pkg::ST_OK, rsp.data == '0)

endmodule

>>> tb/double_ended_queue_tb.sv
// Self-checking testbench for the bounded double-ended queue.
module double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 1024;
  localparam int HALF_PERIOD  = 4;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 12;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 48;
  localparam int REPORT_LIMIT = 10;

  // Op codes the block must ignore.
  localparam logic [dq_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [dq_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
  typedef enum int {LEAN_GROW, LEAN_SHRINK, LEAN_ACCESS, LEAN_EVEN} lean_t;

  // Shadow deque: predicts each reply and holds the replies still owed.
  class deque_scoreboard;
    logic [dq_pkg::VAL_W-1:0] slots [DEPTH];
    logic [dq_pkg::POS_W-1:0] head;
    logic [dq_pkg::CNT_W-1:0] fill;
    dq_pkg::rsp_t             awaited_replies [$];
    int unsigned              mismatches;

    function new();
      head       = '0;
      fill       = '0;
      mismatches = 0;
    endfunction

    // Apply one accepted item to the shadow deque and queue its reply.
    function void apply_op(dq_pkg::req_t r);
      dq_pkg::rsp_t             reply;
      logic [dq_pkg::POS_W-1:0] slot;
      reply = '0;
      case (r.op)
        dq_pkg::OP_PUSH_FRONT: begin
          if (fill == dq_pkg::CNT_W'(DEPTH)) begin
            reply.status = dq_pkg::ST_FULL;
          end else begin
            head        = head - 1'b1;
            slots[head] = r.value;
            fill        = fill + 1'b1;
          end
        end
        dq_pkg::OP_PUSH_BACK: begin
          if (fill == dq_pkg::CNT_W'(DEPTH)) begin
            reply.status = dq_pkg::ST_FULL;
          end else begin
            slot        = head + fill[dq_pkg::POS_W-1:0];
            slots[slot] = r.value;
            fill        = fill + 1'b1;
          end
        end
        dq_pkg::OP_POP_FRONT: begin
          if (fill == '0) begin
            reply.status = dq_pkg::ST_EMPTY;
          end else begin
            reply.data = slots[head];
            head       = head + 1'b1;
            fill       = fill - 1'b1;
          end
        end
        dq_pkg::OP_POP_BACK: begin
          if (fill == '0) begin
            reply.status = dq_pkg::ST_EMPTY;
          end else begin
            slot       = head + fill[dq_pkg::POS_W-1:0] - 1'b1;
            reply.data = slots[slot];
            fill       = fill - 1'b1;
          end
        end
        dq_pkg::OP_READ: begin
          if (r.position >= fill) begin
            reply.status = dq_pkg::ST_RANGE;
          end else begin
            slot       = head + r.position;
            reply.data = slots[slot];
          end
        end
        dq_pkg::OP_WRITE: begin
          if (r.position >= fill) begin
            reply.status = dq_pkg::ST_RANGE;
          end else begin
            slot        = head + r.position;
            slots[slot] = r.value;
          end
        end
        default: ;
      endcase
      reply.count = fill;
      awaited_replies.insert(awaited_replies.size(), reply);
    endfunction

    // Compare one accepted reply with the oldest one owed.
    function void compare_reply(dq_pkg::rsp_t got);
      dq_pkg::rsp_t want;
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected reply: data %h count %0d status %0d",
                   got.data, got.count, got.status);
        return;
      end
      want = awaited_replies[0];
      awaited_replies.delete(0);
      if (got.data !== want.data || got.count !== want.count ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("reply mismatch: data exp %h got %h, count exp %0d got %0d, %s %0d got %0d",
                   want.data, got.data, want.count, got.count, "status exp",
                   want.status, got.status);
      end
    endfunction
  endclass

  logic            clk          = 1'b0;
  logic            rst          = 1'b1;
  logic            req_valid    = 1'b0;
  logic            req_stall;
  dq_pkg::req_t    req          = '0;
  logic            rsp_valid;
  logic            rsp_stall    = 1'b0;
  dq_pkg::rsp_t    rsp;
  logic            hold_off_req = 1'b0;
  int unsigned     cycles       = 0;
  int              burst_left   = 0;
  deque_scoreboard board        = new();

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  double_ended_queue #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (dq_pkg::VAL_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Check replies at the rising edge; bail out if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && rsp_valid && !rsp_stall) board.compare_reply(rsp);
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: switch between stall patterns; honor a long hold-off on request.
  initial begin : reply_side
    stall_mode_t mode;
    int          mode_left;
    mode      = STALL_NONE;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // Hold the output long enough that the block backs up into its input.
        hold_off_req = 1'b0;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        rsp_stall <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 120);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  rsp_stall <= 1'b0;
          STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
          default:     rsp_stall <= ((cycles % 7) < 3);
        endcase
      end
    end
  end

  function automatic dq_pkg::req_t make_req(logic [dq_pkg::OP_W-1:0] op,
                                            logic [dq_pkg::VAL_W-1:0] value,
                                            logic [dq_pkg::POS_W-1:0] position);
    dq_pkg::req_t r;
    r.op       = op;
    r.value    = value;
    r.position = position;
    return r;
  endfunction

  // Draw a random item; the lean sets how pushes, pops and index access mix.
  function automatic dq_pkg::req_t random_req(lean_t lean);
    int                       roll;
    int                       live;
    int                       push_pct;
    int                       pop_pct;
    logic [dq_pkg::OP_W-1:0]  op;
    logic [dq_pkg::POS_W-1:0] position;
    live = board.fill;
    case (lean)
      LEAN_GROW:   begin push_pct = 60; pop_pct = 15; end
      LEAN_SHRINK: begin push_pct = 15; pop_pct = 60; end
      LEAN_ACCESS: begin push_pct = 15; pop_pct = 15; end
      default:     begin push_pct = 35; pop_pct = 35; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < push_pct)
      op = $urandom_range(0, 1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
    else if (roll < push_pct + pop_pct)
      op = $urandom_range(0, 1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT;
    else if (roll < 97)
      op = $urandom_range(0, 1) ? dq_pkg::OP_WRITE : dq_pkg::OP_READ;
    else
      op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    // Mostly a live index, sometimes the first one past the end, sometimes anything.
    roll = $urandom_range(0, 9);
    if (live > 0 && roll < 7)
      position = dq_pkg::POS_W'($urandom_range(0, live - 1));
    else if (roll < 8)
      position = dq_pkg::POS_W'(live);
    else
      position = dq_pkg::POS_W'($urandom);
    return make_req(op, $urandom, position);
  endfunction

  // Offer one item in bursts with random gaps; advance once it is accepted.
  task automatic offer(input dq_pkg::req_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
    board.apply_op(item);
  endtask

  // Drop valid and hold off until every owed reply has come back.
  task automatic wait_for_replies;
    @(negedge clk);
    req_valid <= 1'b0;
    while (board.awaited_replies.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  initial begin : stimulus
    lean_t lean;
    int    lean_left;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty deque: the empty and range error paths and the ignored op codes.
    offer(make_req(dq_pkg::OP_POP_FRONT, '1, '0));
    offer(make_req(dq_pkg::OP_POP_BACK, '1, '1));
    offer(make_req(dq_pkg::OP_READ, '0, '0));
    offer(make_req(dq_pkg::OP_WRITE, '1, '0));
    offer(make_req(OP_SPARE_LO, '0, '0));
    offer(make_req(OP_SPARE_HI, '1, '1));
    // A few elements at both ends, then index access in and out of range.
    offer(make_req(dq_pkg::OP_PUSH_FRONT, '0, '1));
    offer(make_req(dq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF, '0));
    offer(make_req(dq_pkg::OP_PUSH_FRONT, 32'h8000_0001, '0));
    offer(make_req(dq_pkg::OP_READ, '0, 10'd0));
    offer(make_req(dq_pkg::OP_READ, '0, 10'd2));
    offer(make_req(dq_pkg::OP_READ, '0, 10'd3));
    offer(make_req(dq_pkg::OP_READ, '0, '1));
    offer(make_req(dq_pkg::OP_WRITE, 32'hA5A5_A5A5, 10'd1));
    offer(make_req(dq_pkg::OP_READ, '0, 10'd1));
    offer(make_req(dq_pkg::OP_WRITE, 32'h5A5A_5A5A, 10'd3));
    offer(make_req(dq_pkg::OP_POP_BACK, '0, '0));
    offer(make_req(dq_pkg::OP_POP_FRONT, '0, '0));
    offer(make_req(dq_pkg::OP_POP_FRONT, '0, '0));
    offer(make_req(dq_pkg::OP_POP_BACK, '0, '0));
    wait_for_replies();

    // Fill to capacity from both ends while the receiver holds off.
    hold_off_req = 1'b1;
    for (int n = 0; n < DEPTH; n++)
      offer(make_req($urandom_range(0, 1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT,
                     $urandom, dq_pkg::POS_W'($urandom)));
    offer(make_req(dq_pkg::OP_PUSH_FRONT, $urandom, '0));
    offer(make_req(dq_pkg::OP_PUSH_BACK, $urandom, '0));
    offer(make_req(dq_pkg::OP_READ, '0, '1));
    offer(make_req(dq_pkg::OP_WRITE, $urandom, '1));
    offer(make_req(dq_pkg::OP_READ, '0, '1));
    offer(make_req(dq_pkg::OP_WRITE, $urandom, '0));
    offer(make_req(dq_pkg::OP_READ, '0, '0));
    offer(make_req(OP_SPARE_LO, '1, '1));
    wait_for_replies();

    // Random stretches, each leaning toward growth, shrinkage or index access.
    lean      = LEAN_EVEN;
    lean_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (lean_left == 0) begin
        lean      = lean_t'($urandom_range(0, 3));
        lean_left = $urandom_range(20, 80);
      end
      lean_left--;
      if (n == RANDOM_ITEMS / 4) hold_off_req = 1'b1;
      if (n == RANDOM_ITEMS / 2) wait_for_replies();
      offer(random_req(lean));
    end

    wait_for_replies();
    repeat (SETTLE) @(posedge clk);
    if (board.mismatches == 0 && board.awaited_replies.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/dq_pkg.sv
hdl/dq_ctrl.sv
hdl/dq_datapath.sv
hdl/double_ended_queue.sv
tb/double_ended_queue_tb.sv
